// ===== src/mpcc_pkg.sv =====
package mpcc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int GM1_W      = 18;
    localparam int INV_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_GAMMA_M1     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAMMA_M1 = 1'd1;

    localparam logic [GM1_W-1:0] GM1_RESET = 18'd43691;
    localparam logic [INV_W-1:0] INV_RESET = 31'd98304;

    // Conversion direction
    localparam logic CMD_PRIM_TO_CONS = 1'b0;
    localparam logic CMD_CONS_TO_PRIM = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_ZERO_RHO = 2'd2
    } status_t;

    // Long division pipeline: one quotient bit per stage plus an input stage
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 31;
    localparam int DIV_STEPS = DIV_NUM_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    // Upper bound of the kinetic term in conserved to primitive direction
    localparam logic [63:0] KIN_CAP = 64'h2000_0000_0000_0000;

    typedef struct packed {
        logic               cmd;
        logic        [30:0] in_density;
        logic signed [31:0] in_vec_x;
        logic signed [31:0] in_vec_y;
        logic signed [31:0] in_vec_z;
        logic signed [31:0] in_thermo;
        logic signed [31:0] in_field_x;
        logic signed [31:0] in_field_y;
        logic signed [31:0] in_field_z;
        logic signed [31:0] in_clean_scalar;
    } conv_in_t;

    typedef struct packed {
        logic        [30:0] out_density;
        logic signed [31:0] out_vec_x;
        logic signed [31:0] out_vec_y;
        logic signed [31:0] out_vec_z;
        logic signed [31:0] out_thermo;
        logic signed [31:0] out_field_x;
        logic signed [31:0] out_field_y;
        logic signed [31:0] out_field_z;
        logic signed [31:0] out_clean_scalar;
        status_t            status;
    } conv_out_t;

    // Item fields that ride alongside the divider pipelines
    typedef struct packed {
        logic               cmd;
        logic        [30:0] density;
        logic signed [31:0] thermo;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic signed [31:0] clean_scalar;
        logic        [2:0]  vec_neg;
        logic signed [63:0] mag_sq;
    } side_t;

    // Finished primitive to conserved result
    typedef struct packed {
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] energy;
        logic               sat;
    } cons_t;

    typedef struct packed {
        side_t side;
        cons_t cons;
    } late_t;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] val;
    } sat_t;

    // Clamp a 64-bit signed value into 32 bits
    function automatic sat_t sat32(input logic signed [63:0] x);
        sat_t r;
        r.flag = 1'b1;
        if (x > 64'sd2147483647) begin
            r.val = 32'sh7FFF_FFFF;
        end
        else if (x < -64'sd2147483648) begin
            r.val = 32'sh8000_0000;
        end
        else begin
            r.flag = 1'b0;
            r.val  = x[31:0];
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clamp into 32 bits
    function automatic sat_t div_sat(input logic [63:0] q, input logic neg);
        sat_t r;
        r.flag = 1'b1;
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
                r.val = 32'sh7FFF_FFFF;
            end
            else begin
                r.flag = 1'b0;
                r.val  = q[31:0];
            end
        end
        else begin
            if (q > 64'h8000_0000) begin
                r.val = 32'sh8000_0000;
            end
            else begin
                r.flag = 1'b0;
                r.val  = ~q[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/mpcc_div_pipe.sv =====
module mpcc_div_pipe
    import mpcc_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quot
);

    // Numerator bits shift out at the top while quotient bits shift in below
    logic [DIV_NUM_W-1:0] nq_reg  [DIV_STEPS+1];
    logic [DIV_DEN_W-1:0] rem_reg [DIV_STEPS+1];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STEPS+1];

    // Capture operands
    always_ff @(posedge clk)
    begin
        nq_reg[0]  <= num;
        rem_reg[0] <= '0;
        den_reg[0] <= den;
    end

    // One restoring step per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W+1:0] diff;

        assign trial = {rem_reg[k], nq_reg[k][DIV_NUM_W-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (!diff[DIV_DEN_W+1])
            begin
                rem_reg[k+1] <= diff[DIV_DEN_W-1:0];
            end
            else
            begin
                rem_reg[k+1] <= trial[DIV_DEN_W-1:0];
            end
            nq_reg[k+1]  <= {nq_reg[k][DIV_NUM_W-2:0], ~diff[DIV_DEN_W+1]};
            den_reg[k+1] <= den_reg[k];
        end
    end

    assign quot = nq_reg[DIV_STEPS];

endmodule

// ===== src/mpcc_delay.sv =====
module mpcc_delay
    import mpcc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_vld,
    output logic [WIDTH-1:0] out_data
);

    logic             vld_reg  [DEPTH];
    logic [WIDTH-1:0] data_reg [DEPTH];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Advance data
    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_vld  = vld_reg[DEPTH-1];
    assign out_data = data_reg[DEPTH-1];

endmodule

// ===== src/mhd_primitive_conserved_convert.sv =====
// Ideal-MHD cell converter between primitive and conserved form, signed fixed
// point with FRAC_BITS fraction bits. A word is taken at every clock edge where
// start is high; busy stays low, so one word per cycle is sustained. Each result
// is shown on out_word with done high for exactly one cycle, in the order the
// words came in. Velocity and kinetic energy are formed by long-division
// pipelines (one quotient bit per stage over a 64-bit numerator); both
// directions go through the same pipeline, so the delay does not depend on cmd.
// The receiver cannot hold results off. Write gamma_minus_one and
// inv_gamma_minus_one only while no word is in flight.
module mhd_primitive_conserved_convert
    import mpcc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  conv_in_t              in_word,
    output logic                  done,
    output conv_out_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BW       = FRAC_BITS + 34;
    localparam int HW       = BW - 32;
    localparam int HPW      = HW + GM1_W + 1;
    localparam int LPW      = 32 + GM1_W;
    localparam int TW       = BW + GM1_W + 1;
    localparam int DLY      = DIV_LAT - 2;
    localparam int LATENCY  = DIV_LAT + 6;

    localparam logic signed [63:0]   B_HI   = 64'sd1 <<< (32 + FRAC_BITS);
    localparam logic signed [63:0]   B_LO   = -B_HI;
    localparam logic signed [TW-1:0] SAT_HI = TW'(33'sh0_7FFF_FFFF);
    localparam logic signed [TW-1:0] SAT_LO = TW'($signed(33'h1_8000_0000));

    // ------------------------------------------------------------------
    // Configuration registers
    logic [GM1_W-1:0] gm1_reg;
    logic [INV_W-1:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm1_reg <= GM1_RESET;
            inv_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GAMMA_M1)
            begin
                gm1_reg <= cfg_data[GM1_W-1:0];
            end
            if (cfg_index == REG_INV_GAMMA_M1)
            begin
                inv_reg <= cfg_data[INV_W-1:0];
            end
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid chain
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic dly_vld, e_vld_reg, f_vld_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            e_vld_reg  <= 1'b0;
            f_vld_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            e_vld_reg  <= dly_vld;
            f_vld_reg  <= e_vld_reg;
            done_reg   <= f_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the word
    conv_in_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        s1_item_reg <= in_word;
    end

    // ------------------------------------------------------------------
    // Stage 2: first products
    logic signed [31:0] s1_vec [3];
    logic signed [31:0] s1_fld [3];
    logic signed [63:0] mv_full  [3];
    logic signed [63:0] bsq_full [3];
    logic signed [63:0] vsq_full [3];
    logic signed [63:0] pinv_full;

    always_comb
    begin
        s1_vec[0] = s1_item_reg.in_vec_x;
        s1_vec[1] = s1_item_reg.in_vec_y;
        s1_vec[2] = s1_item_reg.in_vec_z;
        s1_fld[0] = s1_item_reg.in_field_x;
        s1_fld[1] = s1_item_reg.in_field_y;
        s1_fld[2] = s1_item_reg.in_field_z;
        for (int i = 0; i < 3; i++)
        begin
            mv_full[i]  = $signed({1'b0, s1_item_reg.in_density}) * s1_vec[i];
            bsq_full[i] = s1_fld[i] * s1_fld[i];
            vsq_full[i] = s1_vec[i] * s1_vec[i];
        end
        pinv_full = s1_item_reg.in_thermo * $signed({1'b0, inv_reg});
    end

    logic signed [63:0] s2_mv_reg  [3];
    logic signed [63:0] s2_bsq_reg [3];
    logic signed [63:0] s2_vsq_reg [3];
    logic signed [63:0] s2_pinv_reg;
    conv_in_t           s2_item_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_mv_reg[i]  <= mv_full[i] >>> FRAC_BITS;
            s2_bsq_reg[i] <= bsq_full[i] >>> FRAC_BITS;
            s2_vsq_reg[i] <= vsq_full[i] >>> FRAC_BITS;
        end
        s2_pinv_reg <= pinv_full >>> FRAC_BITS;
        s2_item_reg <= s1_item_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: clamp momentum, sum squares
    sat_t               mom_sat [3];
    logic signed [63:0] me_next;
    logic signed [63:0] acc1_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mom_sat[i] = sat32(s2_mv_reg[i]);
        end
        me_next   = s2_bsq_reg[0] + s2_bsq_reg[1] + s2_bsq_reg[2];
        acc1_next = s2_vsq_reg[0] + s2_vsq_reg[1] + s2_vsq_reg[2];
    end

    logic signed [31:0] s3_mom_reg [3];
    logic               s3_msat_reg;
    logic signed [63:0] s3_me_reg;
    logic        [63:0] s3_acc1_reg;
    logic signed [63:0] s3_pinv_reg;
    conv_in_t           s3_item_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_mom_reg[i] <= mom_sat[i].val;
        end
        s3_msat_reg <= mom_sat[0].flag | mom_sat[1].flag | mom_sat[2].flag;
        s3_me_reg   <= me_next;
        s3_acc1_reg <= acc1_next;
        s3_pinv_reg <= s2_pinv_reg;
        s3_item_reg <= s2_item_reg;
    end

    // ------------------------------------------------------------------
    // Dividers: three velocity lanes and the kinetic term
    logic signed [31:0]    s3_vec  [3];
    logic        [31:0]    vec_abs [3];
    logic [DIV_NUM_W-1:0]  div_num [4];
    logic [DIV_NUM_W-1:0]  div_quot [4];

    always_comb
    begin
        s3_vec[0] = s3_item_reg.in_vec_x;
        s3_vec[1] = s3_item_reg.in_vec_y;
        s3_vec[2] = s3_item_reg.in_vec_z;
        for (int i = 0; i < 3; i++)
        begin
            vec_abs[i] = s3_vec[i][31] ? (~s3_vec[i] + 32'd1) : s3_vec[i];
            div_num[i] = DIV_NUM_W'(vec_abs[i]) << FRAC_BITS;
        end
        div_num[3] = {s3_acc1_reg[DIV_NUM_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        mpcc_div_pipe u_div
        (
            .clk  (clk),
            .num  (div_num[i]),
            .den  (s3_item_reg.in_density),
            .quot (div_quot[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: kinetic products for primitive to conserved
    logic signed [63:0] mvv_full [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mvv_full[i] = s3_mom_reg[i] * s3_vec[i];
        end
    end

    logic signed [63:0] s4_ke_reg  [3];
    logic signed [31:0] s4_mom_reg [3];
    logic               s4_msat_reg;
    logic signed [63:0] s4_me_reg;
    logic signed [63:0] s4_pinv_reg;
    conv_in_t           s4_item_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_ke_reg[i]  <= mvv_full[i] >>> FRAC_BITS;
            s4_mom_reg[i] <= s3_mom_reg[i];
        end
        s4_msat_reg <= s3_msat_reg;
        s4_me_reg   <= s3_me_reg;
        s4_pinv_reg <= s3_pinv_reg;
        s4_item_reg <= s3_item_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: total energy, pack fields for the delay line
    logic signed [63:0] acc0;
    logic signed [63:0] energy_raw;
    sat_t               energy_sat;
    late_t              late_next;

    always_comb
    begin
        acc0       = s4_ke_reg[0] + s4_ke_reg[1] + s4_ke_reg[2];
        energy_raw = s4_pinv_reg + (acc0 >>> 1) + (s4_me_reg >>> 1);
        energy_sat = sat32(energy_raw);

        late_next.side.cmd          = s4_item_reg.cmd;
        late_next.side.density      = s4_item_reg.in_density;
        late_next.side.thermo       = s4_item_reg.in_thermo;
        late_next.side.field_x      = s4_item_reg.in_field_x;
        late_next.side.field_y      = s4_item_reg.in_field_y;
        late_next.side.field_z      = s4_item_reg.in_field_z;
        late_next.side.clean_scalar = s4_item_reg.in_clean_scalar;
        late_next.side.vec_neg      = {s4_item_reg.in_vec_z[31], s4_item_reg.in_vec_y[31],
                                       s4_item_reg.in_vec_x[31]};
        late_next.side.mag_sq       = s4_me_reg;
        late_next.cons.mom_x        = s4_mom_reg[0];
        late_next.cons.mom_y        = s4_mom_reg[1];
        late_next.cons.mom_z        = s4_mom_reg[2];
        late_next.cons.energy       = energy_sat.val;
        late_next.cons.sat          = s4_msat_reg | energy_sat.flag;
    end

    late_t s5_late_reg;

    always_ff @(posedge clk)
    begin
        s5_late_reg <= late_next;
    end

    // Hold the word until the dividers finish
    logic [$bits(late_t)-1:0] dly_data;
    late_t                    dly_late;

    mpcc_delay #(
        .WIDTH ($bits(late_t)),
        .DEPTH (DLY)
    ) u_delay (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s5_vld_reg),
        .in_data  (s5_late_reg),
        .out_vld  (dly_vld),
        .out_data (dly_data)
    );

    assign dly_late = late_t'(dly_data);

    // ------------------------------------------------------------------
    // Stage E: clamp velocity, form pressure base
    sat_t               vel_sat [3];
    logic        [63:0] kin;
    logic signed [63:0] b_full;
    logic signed [BW-1:0] b_clamp;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vel_sat[i] = div_sat(div_quot[i], dly_late.side.vec_neg[i]);
        end
        kin    = (div_quot[3] > KIN_CAP) ? KIN_CAP : div_quot[3];
        b_full = 64'(dly_late.side.thermo) - $signed({1'b0, kin[63:1]})
                 - (dly_late.side.mag_sq >>> 1);
        // beyond these bounds the pressure saturates for any nonzero gamma-1
        if (b_full > B_HI)
        begin
            b_clamp = B_HI[BW-1:0];
        end
        else if (b_full < B_LO)
        begin
            b_clamp = B_LO[BW-1:0];
        end
        else
        begin
            b_clamp = b_full[BW-1:0];
        end
    end

    late_t                e_late_reg;
    logic signed [31:0]   e_vel_reg [3];
    logic                 e_vsat_reg;
    logic signed [BW-1:0] e_b_reg;

    always_ff @(posedge clk)
    begin
        e_late_reg <= dly_late;
        for (int i = 0; i < 3; i++)
        begin
            e_vel_reg[i] <= vel_sat[i].val;
        end
        e_vsat_reg <= vel_sat[0].flag | vel_sat[1].flag | vel_sat[2].flag;
        e_b_reg    <= b_clamp;
    end

    // ------------------------------------------------------------------
    // Stage F: base times gamma-1 in two partial products
    late_t                 f_late_reg;
    logic signed [31:0]    f_vel_reg [3];
    logic                  f_vsat_reg;
    logic signed [HPW-1:0] f_hi_reg;
    logic        [LPW-1:0] f_lo_reg;

    always_ff @(posedge clk)
    begin
        f_late_reg <= e_late_reg;
        for (int i = 0; i < 3; i++)
        begin
            f_vel_reg[i] <= e_vel_reg[i];
        end
        f_vsat_reg <= e_vsat_reg;
        f_hi_reg   <= $signed(e_b_reg[BW-1:32]) * $signed({1'b0, gm1_reg});
        f_lo_reg   <= e_b_reg[31:0] * gm1_reg;
    end

    // ------------------------------------------------------------------
    // Stage G: combine, clamp pressure, select the result
    logic signed [TW-1:0] p_tot;
    logic signed [TW-1:0] p_shf;
    logic signed [31:0]   p_val;
    logic                 p_flag;
    conv_out_t            out_next;

    always_comb
    begin
        p_tot  = (TW'(f_hi_reg) <<< 32) + TW'($signed({1'b0, f_lo_reg}));
        p_shf  = p_tot >>> FRAC_BITS;
        p_flag = 1'b1;
        if (p_shf > SAT_HI)
        begin
            p_val = 32'sh7FFF_FFFF;
        end
        else if (p_shf < SAT_LO)
        begin
            p_val = 32'sh8000_0000;
        end
        else
        begin
            p_flag = 1'b0;
            p_val  = p_shf[31:0];
        end

        out_next.out_density      = f_late_reg.side.density;
        out_next.out_field_x      = f_late_reg.side.field_x;
        out_next.out_field_y      = f_late_reg.side.field_y;
        out_next.out_field_z      = f_late_reg.side.field_z;
        out_next.out_clean_scalar = f_late_reg.side.clean_scalar;
        unique case (f_late_reg.side.cmd)
            CMD_PRIM_TO_CONS:
            begin
                out_next.out_vec_x  = f_late_reg.cons.mom_x;
                out_next.out_vec_y  = f_late_reg.cons.mom_y;
                out_next.out_vec_z  = f_late_reg.cons.mom_z;
                out_next.out_thermo = f_late_reg.cons.energy;
                out_next.status     = f_late_reg.cons.sat ? STATUS_SAT : STATUS_OK;
            end
            CMD_CONS_TO_PRIM:
            begin
                out_next.out_vec_x  = f_vel_reg[0];
                out_next.out_vec_y  = f_vel_reg[1];
                out_next.out_vec_z  = f_vel_reg[2];
                out_next.out_thermo = p_val;
                out_next.status     = (f_vsat_reg | p_flag) ? STATUS_SAT : STATUS_OK;
            end
            default:
            begin
                out_next.out_vec_x  = '0;
                out_next.out_vec_y  = '0;
                out_next.out_vec_z  = '0;
                out_next.out_thermo = '0;
                out_next.status     = STATUS_OK;
            end
        endcase

        // zero density drops every field
        if (f_late_reg.side.density == '0)
        begin
            out_next        = '0;
            out_next.status = STATUS_ZERO_RHO;
        end
    end

    conv_out_t out_word_reg;

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_next;
    end

    assign out_word = out_word_reg;
    assign done     = done_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not complete at the fixed latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted word");

    a_density_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |->
            ##LATENCY (out_word.out_density == $past(in_word.in_density, LATENCY)))
        else $error("density not carried through the pipeline");

    a_zero_rho: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_word.in_density == '0) |->
            ##LATENCY (out_word.status == STATUS_ZERO_RHO && out_word.out_vec_x == '0))
        else $error("zero density word not flagged");

endmodule

// ===== dv/mhd_primitive_conserved_convert_test.sv =====
module mhd_primitive_conserved_convert_test;
    import mpcc_pkg::*;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 70;
    localparam int WDOG_MAX = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    conv_in_t              in_word;
    logic                  done;
    conv_out_t             out_word;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mhd_primitive_conserved_convert #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers
    logic [GM1_W-1:0] gm1_q;
    logic [INV_W-1:0] inv_q;

    conv_in_t  cell_queue[$];
    conv_out_t cons_expected[$];
    int        mismatches;
    int        watchdog;
    bit        timed_out;
    bit        stim_done;
    bit        idle_on;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Floor shift of a product by the fraction width
    function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
                                                 input logic signed [127:0] b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic logic signed [127:0] clamp32(input logic signed [127:0] x,
                                                    inout bit flag);
        if (x > 128'sd2147483647)
        begin
            flag = 1'b1;
            return 128'sd2147483647;
        end
        if (x < -128'sd2147483648)
        begin
            flag = 1'b1;
            return -128'sd2147483648;
        end
        return x;
    endfunction

    // Convert one cell as the block should
    function automatic conv_out_t convert_cell(input conv_in_t c);
        conv_out_t o;
        logic signed [127:0] rho, v[3], b[3], res[3];
        logic signed [127:0] me, acc, th, kin, bal, bh, bl, num;
        bit flag;
        me = 0;
        acc = 0;
        flag = 1'b0;
        rho = $signed({97'd0, c.in_density});
        v[0] = c.in_vec_x;
        v[1] = c.in_vec_y;
        v[2] = c.in_vec_z;
        b[0] = c.in_field_x;
        b[1] = c.in_field_y;
        b[2] = c.in_field_z;
        o = '0;
        for (int i = 0; i < 3; i++)
            me += qmul(b[i], b[i]);
        if (rho == 0)
        begin
            o.status = STATUS_ZERO_RHO;
            return o;
        end
        if (c.cmd == CMD_PRIM_TO_CONS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res[i] = clamp32(qmul(rho, v[i]), flag);
                acc += qmul(res[i], v[i]);
            end
            th = qmul(c.in_thermo, $signed({97'd0, inv_q})) + (acc >>> 1) + (me >>> 1);
            th = clamp32(th, flag);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                // Truncate toward zero
                num = v[i] <<< FRAC;
                res[i] = clamp32(num / rho, flag);
                acc += qmul(v[i], v[i]);
            end
            kin = (acc * (128'sd1 <<< FRAC)) / rho;
            if (kin > (128'sd1 <<< 61))
                kin = 128'sd1 <<< 61;
            bal = $signed(c.in_thermo) - (kin >>> 1) - (me >>> 1);
            if (gm1_q == 0)
                th = 0;
            else
            begin
                bh = bal >>> FRAC;
                bl = bal - (bh <<< FRAC);
                if (bh >= (128'sd1 <<< 32))
                    th = clamp32(128'sd1 <<< 32, flag);
                else if (bh < -(128'sd1 <<< 32))
                    th = clamp32(-(128'sd1 <<< 32), flag);
                else
                    th = clamp32(bh * $signed({110'd0, gm1_q})
                                 + ((bl * $signed({110'd0, gm1_q})) >>> FRAC), flag);
            end
        end
        o.out_density      = c.in_density;
        o.out_vec_x        = res[0][31:0];
        o.out_vec_y        = res[1][31:0];
        o.out_vec_z        = res[2][31:0];
        o.out_thermo       = th[31:0];
        o.out_field_x      = c.in_field_x;
        o.out_field_y      = c.in_field_y;
        o.out_field_z      = c.in_field_z;
        o.out_clean_scalar = c.in_clean_scalar;
        o.status           = flag ? STATUS_SAT : STATUS_OK;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 16) - 8;
            3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic conv_in_t rnd_cell();
        conv_in_t c;
        c.cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: c.in_density = '0;
            1: c.in_density = 31'h7FFF_FFFF;
            2: c.in_density = 31'($urandom_range(1, 16));
            3, 4: c.in_density = 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
            default: c.in_density = 31'($urandom);
        endcase
        c.in_vec_x        = rnd_val();
        c.in_vec_y        = rnd_val();
        c.in_vec_z        = rnd_val();
        c.in_thermo       = rnd_val();
        c.in_field_x      = rnd_val();
        c.in_field_y      = rnd_val();
        c.in_field_z      = rnd_val();
        c.in_clean_scalar = rnd_val();
        return c;
    endfunction

    // Drive the next pending word; hold start high through back-to-back words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (start && !busy)
                cons_expected.push_back(convert_cell(in_word));
            if ((!start || !busy) && cell_queue.size() > 0
                && !(idle_on && $urandom_range(0, 99) < 26))
            begin
                start   <= 1'b1;
                in_word <= cell_queue.pop_front();
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        conv_out_t e;
        if (rst_n && done)
        begin
            if (cons_expected.size() == 0)
                report_mismatch("unexpected word", 64'd0, 64'd0);
            else
            begin
                e = cons_expected.pop_front();
                if (out_word.out_density != e.out_density)
                    report_mismatch("density", 64'(out_word.out_density),
                                    64'(e.out_density));
                if (out_word.out_vec_x != e.out_vec_x)
                    report_mismatch("vec_x", 64'(out_word.out_vec_x), 64'(e.out_vec_x));
                if (out_word.out_vec_y != e.out_vec_y)
                    report_mismatch("vec_y", 64'(out_word.out_vec_y), 64'(e.out_vec_y));
                if (out_word.out_vec_z != e.out_vec_z)
                    report_mismatch("vec_z", 64'(out_word.out_vec_z), 64'(e.out_vec_z));
                if (out_word.out_thermo != e.out_thermo)
                    report_mismatch("thermo", 64'(out_word.out_thermo), 64'(e.out_thermo));
                if (out_word.out_field_x != e.out_field_x)
                    report_mismatch("field_x", 64'(out_word.out_field_x),
                                    64'(e.out_field_x));
                if (out_word.out_field_y != e.out_field_y)
                    report_mismatch("field_y", 64'(out_word.out_field_y),
                                    64'(e.out_field_y));
                if (out_word.out_field_z != e.out_field_z)
                    report_mismatch("field_z", 64'(out_word.out_field_z),
                                    64'(e.out_field_z));
                if (out_word.out_clean_scalar != e.out_clean_scalar)
                    report_mismatch("clean_scalar", 64'(out_word.out_clean_scalar),
                                    64'(e.out_clean_scalar));
                if (out_word.status != e.status)
                    report_mismatch("status", 64'(out_word.status), 64'(e.status));
            end
        end
    end

    // Count cycles without progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n || stim_done)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic drain();
        while (cell_queue.size() > 0 || start || cons_expected.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GAMMA_M1)
            gm1_q = val[GM1_W-1:0];
        else
            inv_q = val[INV_W-1:0];
    endtask

    task automatic run_phase(input int n, input logic [GM1_W-1:0] g,
                             input logic [INV_W-1:0] inv);
        write_reg(REG_GAMMA_M1, CFG_DATA_W'(g));
        write_reg(REG_INV_GAMMA_M1, CFG_DATA_W'(inv));
        for (int i = 0; i < n; i++)
            cell_queue.push_back(rnd_cell());
        drain();
    endtask

    initial
    begin
        conv_in_t c;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        stim_done  = 1'b0;
        idle_on    = 1'b1;
        gm1_q      = GM1_RESET;
        inv_q      = INV_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, both directions, zero density, saturation
        for (int k = 0; k < 20; k++)
        begin
            c = '0;
            c.cmd = k[0] ? CMD_CONS_TO_PRIM : CMD_PRIM_TO_CONS;
            c.in_density = (k < 2) ? 31'd0 : (k < 6) ? 31'h7FFF_FFFF
                         : (k < 10) ? 31'd1 : 31'h0001_0000;
            c.in_vec_x        = (k & 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            c.in_vec_y        = (k & 4) ? 32'hFFFF_FFFF : 32'h0001_0000;
            c.in_vec_z        = (k & 8) ? 32'h8000_0000 : 32'h0;
            c.in_thermo       = (k & 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            c.in_field_x      = (k & 4) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            c.in_field_y      = (k & 8) ? 32'h0 : 32'hFFFF_FFFF;
            c.in_field_z      = (k & 16) ? 32'h8000_0000 : 32'h0001_0000;
            c.in_clean_scalar = (k & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (k >= 16)
            begin
                c.in_vec_x = 32'h0001_0000;
                c.in_vec_y = 32'h0002_0000;
                c.in_vec_z = 32'hFFFF_0000;
                c.in_thermo = 32'h000A_0000;
                c.in_field_x = 32'h0000_8000;
                c.in_field_y = 32'h0;
                c.in_field_z = 32'h0;
            end
            cell_queue.push_back(c);
        end
        drain();

        // Random phases across register settings, extremes among them
        run_phase(300, 18'd43691, 31'd98304);
        run_phase(200, 18'd196608, 31'd1);
        run_phase(200, 18'd1, 31'h7FFF_FFFF);
        run_phase(100, 18'd0, 31'd0);
        idle_on = 1'b0;
        run_phase(350, 18'd26214, 31'd163840);
        idle_on = 1'b1;
        run_phase(250, 18'd65536, 31'd65536);
        run_phase(250, GM1_W'($urandom_range(1, 196608)),
                  INV_W'($urandom_range(1, 32'h7FFF_FFFF)));

        stim_done = 1'b1;
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
